[hw/rtl/rc4_pkg.sv]
// Package for the RC4 stream cipher block: sizes, command codes and register indexes.
// It has no dependencies. rc4_stream_cipher uses it through scoped names.

package rc4_pkg;

    // Permutation and byte sizes.
    localparam int PERM_DEPTH = 256;
    localparam int IDX_W      = 8;
    localparam int BYTE_W     = 8;

    // Key storage: up to 32 bytes, packed into four 64-bit words.
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_IDX_W     = 5;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_LEN_W     = 6;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;

    // Command codes of the input channel.
    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_KEY_SCHEDULE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CRYPT        = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART      = 2'd2;

    // Key length in use is turned into length minus one, so it indexes key bytes directly.
    localparam logic [KEY_IDX_W-1:0] KEY_LAST_MAX = 5'(MAX_KEY_BYTES - 1);

endpackage

[hw/rtl/rc4_stream_cipher.sv]
// RC4 stream cipher: sequencer, key registers and the 256-byte permutation memory.
// Depends on rc4_pkg.

// RC4 byte stream cipher with a 256 x 8 permutation held in a single-port-write,
// single-port-read memory with registered read data. Every permutation access goes
// through that one memory port pair under a small sequencer, which sets all timings.
// A crypt (command 1) keeps the input busy through READ_I, READ_J, SWAP_I, SWAP_J,
// FINAL and OUT, and OUT waits for a free output register; a crypt before any key
// schedule goes straight to OUT. The key schedule (command 0) fills the memory with
// the identity and then runs RD_A, CALC, SWAP_A and SWAP_B for each entry before
// the input is ready again. A restart (command 2) and the unused code keep it ready.
// A finished result waits in the output register while the next item is accepted.
// Configuration writes are taken at any time and should only be issued while idle.

module rc4_stream_cipher (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Configuration write port.
    input  logic                                 cfg_wr_en,
    input  logic [rc4_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]       cfg_wr_data,

    // Input channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rc4_pkg::CMD_W-1:0]            s_command,
    input  logic [rc4_pkg::BYTE_W-1:0]           s_data_in,

    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rc4_pkg::BYTE_W-1:0]           m_data_out,
    output logic                                 m_not_keyed
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_INIT,
        ST_KS_RD_A,
        ST_KS_CALC,
        ST_KS_SWAP_A,
        ST_KS_SWAP_B,
        ST_C_READ_I,
        ST_C_READ_J,
        ST_C_SWAP_I,
        ST_C_SWAP_J,
        ST_C_FINAL,
        ST_C_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [rc4_pkg::KEY_WORDS-1:0][rc4_pkg::KEY_WORD_W-1:0] key_word_reg;
    logic [rc4_pkg::KEY_LEN_W-1:0]                          key_length_reg;

    // Cipher state.
    logic [rc4_pkg::IDX_W-1:0]     i_reg;
    logic [rc4_pkg::IDX_W-1:0]     j_reg;
    logic                          keyed_reg;

    // Key schedule counters.
    logic [rc4_pkg::IDX_W-1:0]     a_reg;
    logic [rc4_pkg::IDX_W-1:0]     b_reg;
    logic [rc4_pkg::KEY_IDX_W-1:0] kidx_reg;

    // Working registers of one transaction.
    logic [rc4_pkg::BYTE_W-1:0]    si_reg;
    logic [rc4_pkg::BYTE_W-1:0]    sj_reg;
    logic [rc4_pkg::BYTE_W-1:0]    data_reg;
    logic                          byp_reg;
    logic [rc4_pkg::BYTE_W-1:0]    res_data_reg;
    logic                          res_nk_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [rc4_pkg::BYTE_W-1:0]    m_data_reg;
    logic                          m_nk_reg;

    // Permutation memory.
    logic [rc4_pkg::BYTE_W-1:0]    perm_mem [rc4_pkg::PERM_DEPTH];
    logic [rc4_pkg::BYTE_W-1:0]    mem_rdata_reg;
    logic                          mem_we;
    logic [rc4_pkg::IDX_W-1:0]     mem_waddr;
    logic [rc4_pkg::BYTE_W-1:0]    mem_wdata;
    logic [rc4_pkg::IDX_W-1:0]     mem_raddr;

    logic [rc4_pkg::BYTE_W-1:0]    key_byte;
    logic [rc4_pkg::KEY_IDX_W-1:0] key_last;
    logic [rc4_pkg::IDX_W-1:0]     b_next;
    logic [rc4_pkg::IDX_W-1:0]     j_next;
    logic [rc4_pkg::IDX_W-1:0]     ks_addr;
    logic [rc4_pkg::BYTE_W-1:0]    ks_byte;
    logic                          s_accept;
    logic                          out_free;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_data_out  = m_data_reg;
    assign m_not_keyed = m_nk_reg;

    // Last key byte index in use: a length of zero counts as one, long keys saturate.
    always_comb begin
        if (key_length_reg == '0) begin
            key_last = '0;
        end else if (key_length_reg > rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES)) begin
            key_last = rc4_pkg::KEY_LAST_MAX;
        end else begin
            key_last = rc4_pkg::KEY_IDX_W'(key_length_reg - 1'b1);
        end
    end

    // Key byte selected by the cyclic key counter.
    assign key_byte = key_word_reg[kidx_reg[rc4_pkg::KEY_IDX_W-1:3]][{kidx_reg[2:0], 3'b000} +: 8];

    // Index arithmetic, all modulo 256.
    assign b_next  = b_reg + mem_rdata_reg + key_byte;
    assign j_next  = j_reg + mem_rdata_reg;
    assign ks_addr = si_reg + sj_reg;
    assign ks_byte = byp_reg ? si_reg : mem_rdata_reg;

    // Memory port control for each sequencer step.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = a_reg;
        mem_wdata = a_reg;
        mem_raddr = a_reg;
        case (state_reg)
            ST_KS_INIT: begin
                mem_we = 1'b1;
            end
            ST_KS_RD_A: begin
                mem_raddr = a_reg;
            end
            ST_KS_CALC: begin
                mem_raddr = b_next;
            end
            ST_KS_SWAP_A: begin
                mem_we    = 1'b1;
                mem_waddr = a_reg;
                mem_wdata = mem_rdata_reg;
            end
            ST_KS_SWAP_B: begin
                mem_we    = 1'b1;
                mem_waddr = b_reg;
                mem_wdata = si_reg;
            end
            ST_C_READ_I: begin
                mem_raddr = i_reg;
            end
            ST_C_READ_J: begin
                mem_raddr = j_next;
            end
            ST_C_SWAP_I: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = mem_rdata_reg;
            end
            ST_C_SWAP_J: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                mem_raddr = ks_addr;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Permutation memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= perm_mem[mem_raddr];
    end

    // Sequencer, cipher state, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            key_word_reg   <= '0;
            key_length_reg <= rc4_pkg::KEY_LEN_W'(1);
            i_reg          <= '0;
            j_reg          <= '0;
            keyed_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Configuration writes; indexes past the key length register are ignored.
            if (cfg_wr_en) begin
                if (cfg_index < rc4_pkg::CFG_INDEX_W'(rc4_pkg::KEY_WORDS)) begin
                    key_word_reg[cfg_index[1:0]] <= cfg_wr_data;
                end else if (cfg_index == rc4_pkg::REG_KEY_LENGTH) begin
                    key_length_reg <= cfg_wr_data[rc4_pkg::KEY_LEN_W-1:0];
                end
            end

            // The downstream side takes the waiting result; a result handed over in
            // the same cycle sets the register again below.
            if (m_valid_reg && m_ready && state_reg != ST_C_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        data_reg <= s_data_in;
                        case (s_command)
                            rc4_pkg::CMD_KEY_SCHEDULE: begin
                                a_reg     <= '0;
                                state_reg <= ST_KS_INIT;
                            end
                            rc4_pkg::CMD_CRYPT: begin
                                if (keyed_reg) begin
                                    i_reg     <= i_reg + 1'b1;
                                    state_reg <= ST_C_READ_I;
                                end else begin
                                    res_data_reg <= s_data_in;
                                    res_nk_reg   <= 1'b1;
                                    state_reg    <= ST_C_OUT;
                                end
                            end
                            rc4_pkg::CMD_RESTART: begin
                                i_reg <= '0;
                                j_reg <= '0;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // Fill the permutation with the identity.
                ST_KS_INIT: begin
                    a_reg <= a_reg + 1'b1;
                    if (a_reg == rc4_pkg::IDX_W'(rc4_pkg::PERM_DEPTH - 1)) begin
                        b_reg     <= '0;
                        kidx_reg  <= '0;
                        state_reg <= ST_KS_RD_A;
                    end
                end

                ST_KS_RD_A: begin
                    state_reg <= ST_KS_CALC;
                end

                // S[a] is here: step b and fetch S[b].
                ST_KS_CALC: begin
                    si_reg    <= mem_rdata_reg;
                    b_reg     <= b_next;
                    state_reg <= ST_KS_SWAP_A;
                end

                ST_KS_SWAP_A: begin
                    state_reg <= ST_KS_SWAP_B;
                end

                // Second half of the swap; move to the next entry and key byte.
                ST_KS_SWAP_B: begin
                    a_reg    <= a_reg + 1'b1;
                    kidx_reg <= (kidx_reg == key_last) ? '0 : kidx_reg + 1'b1;
                    if (a_reg == rc4_pkg::IDX_W'(rc4_pkg::PERM_DEPTH - 1)) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        keyed_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_KS_RD_A;
                    end
                end

                ST_C_READ_I: begin
                    state_reg <= ST_C_READ_J;
                end

                // S[i] is here: step j and fetch S[j].
                ST_C_READ_J: begin
                    si_reg    <= mem_rdata_reg;
                    j_reg     <= j_next;
                    state_reg <= ST_C_SWAP_I;
                end

                ST_C_SWAP_I: begin
                    sj_reg    <= mem_rdata_reg;
                    state_reg <= ST_C_SWAP_J;
                end

                // The keystream read goes out with the write of S[j]; when it hits j the
                // memory still returns the old value, so the new one is forwarded.
                ST_C_SWAP_J: begin
                    byp_reg   <= (ks_addr == j_reg);
                    state_reg <= ST_C_FINAL;
                end

                ST_C_FINAL: begin
                    res_data_reg <= data_reg ^ ks_byte;
                    res_nk_reg   <= 1'b0;
                    state_reg    <= ST_C_OUT;
                end

                // Hand the result to the output register once it is free.
                ST_C_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_data_reg;
                        m_nk_reg    <= res_nk_reg;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // A keyed result can only come out once a key schedule has completed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_not_keyed) |-> keyed_reg)
        else $error("keyed result without a completed key schedule");

    // A key schedule transaction keeps the input busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == rc4_pkg::CMD_KEY_SCHEDULE) |=> !s_ready)
        else $error("input ready right after a key schedule was accepted");

    // A restart transaction clears both counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == rc4_pkg::CMD_RESTART)
            |=> (i_reg == '0 && j_reg == '0))
        else $error("counters not cleared by restart");

    // The permutation is never written while the sequencer is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("permutation write while idle");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (!$rose(state_reg == ST_IDLE) || $past(state_reg) != ST_C_OUT))
        else $error("waiting result overwritten");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench for rc4_stream_cipher: directed and random command streams,
// checked against a behavioral RC4 predictor held in the testbench.
// Depends on rc4_pkg and the rc4_stream_cipher RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The fourth command code has no meaning in the block and must be ignored.
    localparam logic [rc4_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Key word registers sit at consecutive indexes below the key length register.
    localparam logic [rc4_pkg::CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam int LAST_CFG_INDEX = (1 << rc4_pkg::CFG_INDEX_W) - 1;

    // The settle time must outlast a full key schedule.
    localparam int SETTLE_CYCLES    = 1400;
    localparam int RANDOM_ITEMS     = 1400;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_ITEMS       = 40;

    typedef struct packed {
        logic [rc4_pkg::BYTE_W-1:0] data_out;
        logic                       not_keyed;
    } crypt_result_t;

    // DUT connections.
    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    logic [rc4_pkg::CMD_W-1:0]       s_command;
    logic [rc4_pkg::BYTE_W-1:0]      s_data_in;
    logic                            m_valid;
    logic                            m_ready;
    logic [rc4_pkg::BYTE_W-1:0]      m_data_out;
    logic                            m_not_keyed;

    // Predictor state: permutation, counters, keyed flag and key registers.
    logic [rc4_pkg::BYTE_W-1:0]     perm_model [rc4_pkg::PERM_DEPTH];
    logic [rc4_pkg::IDX_W-1:0]      ctr_i = '0;
    logic [rc4_pkg::IDX_W-1:0]      ctr_j = '0;
    bit                             keyed_model = 1'b0;
    logic [rc4_pkg::KEY_WORD_W-1:0] key_word_model [rc4_pkg::KEY_WORDS] = '{default: '0};
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_model = 6'd1;

    crypt_result_t pending_crypts[$];
    int            mismatch_count = 0;
    int            burst_left = 0;
    int            ready_pct = 100;
    bit            long_hold_req = 1'b0;

    rc4_stream_cipher uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_not_keyed (m_not_keyed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #8ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Key byte k of the configured key, byte k of a word at bits 8k upward.
    function automatic logic [rc4_pkg::BYTE_W-1:0] key_byte_at(int unsigned k);
        return key_word_model[k / 8][(k % 8) * 8 +: 8];
    endfunction

    // RC4 key schedule over the configured key; length 0 acts as 1, above 32 as 32.
    function automatic void expand_key();
        int unsigned                len;
        logic [rc4_pkg::IDX_W-1:0]  j;
        logic [rc4_pkg::BYTE_W-1:0] t;
        len = 32'(key_len_model);
        if (len == 0) len = 1;
        if (len > rc4_pkg::MAX_KEY_BYTES) len = rc4_pkg::MAX_KEY_BYTES;
        for (int a = 0; a < rc4_pkg::PERM_DEPTH; a++) perm_model[a] = rc4_pkg::BYTE_W'(a);
        j = '0;
        for (int a = 0; a < rc4_pkg::PERM_DEPTH; a++) begin
            j = j + perm_model[a] + key_byte_at(a % len);
            t = perm_model[a];
            perm_model[a] = perm_model[j];
            perm_model[j] = t;
        end
        ctr_i = '0;
        ctr_j = '0;
        keyed_model = 1'b1;
    endfunction

    // One step of the RC4 generator.
    function automatic logic [rc4_pkg::BYTE_W-1:0] next_keystream_byte();
        logic [rc4_pkg::BYTE_W-1:0] t;
        ctr_i = ctr_i + 1'b1;
        ctr_j = ctr_j + perm_model[ctr_i];
        t = perm_model[ctr_i];
        perm_model[ctr_i] = perm_model[ctr_j];
        perm_model[ctr_j] = t;
        return perm_model[rc4_pkg::IDX_W'(perm_model[ctr_i] + perm_model[ctr_j])];
    endfunction

    // Update the predictor for one accepted transaction and queue its result, if any.
    function automatic void predict_command(logic [rc4_pkg::CMD_W-1:0] cmd,
                                            logic [rc4_pkg::BYTE_W-1:0] data);
        crypt_result_t res;
        case (cmd)
            rc4_pkg::CMD_KEY_SCHEDULE: expand_key();
            rc4_pkg::CMD_RESTART: begin
                ctr_i = '0;
                ctr_j = '0;
            end
            rc4_pkg::CMD_CRYPT: begin
                // Before any key schedule the byte passes through and is flagged.
                if (keyed_model) begin
                    res.data_out  = data ^ next_keystream_byte();
                    res.not_keyed = 1'b0;
                end else begin
                    res.data_out  = data;
                    res.not_keyed = 1'b1;
                end
                pending_crypts.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_item(input logic [rc4_pkg::CMD_W-1:0] cmd,
                             input logic [rc4_pkg::BYTE_W-1:0] data);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_data_in <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_command(cmd, data);
    endtask

    // Sender pacing: bursts of random length with random gaps, some long gapless runs.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 10);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_results_drained();
        while (pending_crypts.size() != 0) @(posedge aclk);
    endtask

    // Bring the block to idle: no results owed and any key schedule finished.
    task automatic settle_block();
        s_valid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the caller lowers the write enable after its last write.
    task automatic write_register(input logic [rc4_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [rc4_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        if (idx < rc4_pkg::REG_KEY_LENGTH) begin
            key_word_model[idx[1:0]] = value;
        end else if (idx == rc4_pkg::REG_KEY_LENGTH) begin
            key_len_model = value[rc4_pkg::KEY_LEN_W-1:0];
        end
    endtask

    task automatic load_key(input logic [rc4_pkg::KEY_WORD_W-1:0] w0,
                            input logic [rc4_pkg::KEY_WORD_W-1:0] w1,
                            input logic [rc4_pkg::KEY_WORD_W-1:0] w2,
                            input logic [rc4_pkg::KEY_WORD_W-1:0] w3,
                            input logic [rc4_pkg::KEY_LEN_W-1:0] len);
        logic [rc4_pkg::KEY_WORD_W-1:0] words [rc4_pkg::KEY_WORDS];
        words = '{w0, w1, w2, w3};
        for (int w = 0; w < rc4_pkg::KEY_WORDS; w++) begin
            write_register(rc4_pkg::CFG_INDEX_W'(REG_KEY_WORD_0 + w), words[w]);
        end
        write_register(rc4_pkg::REG_KEY_LENGTH, rc4_pkg::CFG_DATA_W'(len));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [rc4_pkg::KEY_WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Crypt, restart and unused commands before any key schedule.
    task automatic test_unkeyed();
        send_item(rc4_pkg::CMD_CRYPT, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'hFF);
        send_item(rc4_pkg::CMD_RESTART, 8'h00);
        send_item(CMD_UNUSED, 8'hFF);
        send_item(rc4_pkg::CMD_CRYPT, 8'h5A);
    endtask

    // Key schedule with the reset key (one zero byte), then a restart of the stream.
    task automatic test_default_key();
        send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'hFF);
        send_item(rc4_pkg::CMD_CRYPT, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'hFF);
        send_item(rc4_pkg::CMD_RESTART, 8'hA5);
        send_item(rc4_pkg::CMD_CRYPT, 8'h00);
    endtask

    // Unused command code and back-to-back restarts in a keyed stream.
    task automatic test_restart_and_unused();
        send_item(rc4_pkg::CMD_CRYPT, 8'h3C);
        send_item(CMD_UNUSED, 8'h81);
        send_item(rc4_pkg::CMD_CRYPT, 8'hC3);
        send_item(rc4_pkg::CMD_RESTART, 8'h00);
        send_item(rc4_pkg::CMD_RESTART, 8'hFF);
        send_item(rc4_pkg::CMD_CRYPT, 8'h7E);
    endtask

    // Writes to unmapped indexes, key length zero, the maximum and a saturated length.
    task automatic test_key_length_limits();
        settle_block();
        for (int idx = rc4_pkg::REG_KEY_LENGTH + 1; idx <= LAST_CFG_INDEX; idx++) begin
            write_register(rc4_pkg::CFG_INDEX_W'(idx), '1);
        end
        load_key('1, '1, '1, '1, 6'd0);
        send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'hFF);
        settle_block();
        load_key(random_word(), random_word(), random_word(), random_word(),
                 6'(rc4_pkg::MAX_KEY_BYTES));
        send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'h96);
        settle_block();
        load_key(random_word(), random_word(), random_word(), random_word(), '1);
        send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'h69);
    endtask

    // The receiver holds off long enough for the block to stall its input, then
    // the sender waits for every result and goes on against random receiver stalls.
    task automatic test_output_stall();
        settle_block();
        ready_pct = 100;
        load_key(random_word(), random_word(), random_word(), random_word(), 6'd16);
        send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'h00);
        send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
        s_valid <= 1'b0;
        wait_results_drained();
        long_hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
        s_valid <= 1'b0;
        wait_results_drained();
        ready_pct = 60;
        repeat (HOLD_ITEMS) begin
            pace_sender();
            send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
        end
    endtask

    // Random phases: mostly a key schedule followed by a long crypt stream,
    // with restarts, unused codes and the occasional rekey mixed in.
    task automatic test_random_traffic();
        int sent;
        int stream_len;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_block();
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                load_key(random_word(), random_word(), random_word(), random_word(),
                         (pick == 0) ? 6'd0 :
                         (pick == 1) ? 6'($urandom_range(rc4_pkg::MAX_KEY_BYTES + 1, 63)) :
                         (pick == 2) ? 6'(rc4_pkg::MAX_KEY_BYTES) :
                         (pick == 3) ? 6'd1 : 6'($urandom_range(1, rc4_pkg::MAX_KEY_BYTES)));
            end
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 80;
                2: ready_pct = 50;
                default: ready_pct = 20;
            endcase
            // A few phases carry on with the old permutation and counters.
            if ($urandom_range(0, 99) < 85) begin
                send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'($urandom));
                sent++;
            end
            stream_len = $urandom_range(20, 120);
            for (int n = 0; n < stream_len; n++) begin
                pick = $urandom_range(0, 99);
                pace_sender();
                if (pick < 88) begin
                    send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
                    sent++;
                end else if (pick < 94) begin
                    send_item(rc4_pkg::CMD_RESTART, 8'($urandom));
                    sent++;
                end else if (pick < 97) begin
                    send_item(CMD_UNUSED, 8'($urandom));
                end else begin
                    send_item(rc4_pkg::CMD_KEY_SCHEDULE, 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Result receiver: random stalls at a per-phase rate, plus a long hold on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expected one.
    always @(posedge aclk) begin
        crypt_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_crypts.size() == 0) begin
                $error("unexpected result: data_out %h not_keyed %b", m_data_out, m_not_keyed);
                mismatch_count++;
            end else begin
                exp_res = pending_crypts.pop_front();
                if (m_data_out !== exp_res.data_out) begin
                    $error("data_out: expected %h, actual %h", exp_res.data_out, m_data_out);
                    mismatch_count++;
                end
                if (m_not_keyed !== exp_res.not_keyed) begin
                    $error("not_keyed: expected %b, actual %b", exp_res.not_keyed, m_not_keyed);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_KEY_WORD_0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_command   <= rc4_pkg::CMD_RESTART;
        s_data_in   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unkeyed();
        test_default_key();
        test_restart_and_unused();
        test_key_length_limits();
        test_output_stall();
        test_random_traffic();

        settle_block();
        if (pending_crypts.size() != 0) begin
            $error("%0d expected results never arrived", pending_crypts.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
